FILE: src/log_segment_ring_manager_macros.svh
// assertion macros
`ifndef LOG_SEGMENT_RING_MANAGER_MACROS_SVH
`define LOG_SEGMENT_RING_MANAGER_MACROS_SVH
`define LSRM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define LSRM_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

FILE: src/lsrm_pkg.sv
package lsrm_pkg;
   localparam int unsigned RingSlotsDefault   = 16;
   localparam int unsigned HeaderBytesDefault = 4096;
   localparam int unsigned FooterBytesDefault = 4096;

   typedef enum logic [2:0] {
      ST_EMPTY = 3'd0, ST_READY = 3'd1, ST_ACTIVE = 3'd2, ST_SEALED = 3'd3,
      ST_RECYCLABLE = 3'd4
   } slot_state_type;

   typedef enum logic [2:0] {
      MODE_APPEND = 3'd0, MODE_ROTATE = 3'd1, MODE_SEAL = 3'd2, MODE_RELEASE = 3'd3,
      MODE_PRECREATE = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      STS_OK = 3'd0, STS_ROTATE = 3'd1, STS_NO_READY = 3'd2, STS_NO_ACTIVE = 3'd3,
      STS_NONE = 3'd4
   } status_type;

   localparam logic [1:0] REG_SIZE = 2'd0;
   localparam logic [1:0] REG_USED = 2'd1;
   localparam logic [1:0] REG_TARGET = 2'd2;

   typedef enum logic [3:0] {
      FSM_IDLE, FSM_DISPATCH, FSM_ACT_SCAN, FSM_APPEND, FSM_REL_SCAN,
      FSM_EMPTY_SCAN, FSM_RECY_SCAN, FSM_CREATE, FSM_SEAL, FSM_DONE
   } fsm_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // capture request
      logic scan_clear;  // restart scan index
      logic scan_step;   // advance scan index
      logic activate;    // activate scanned slot
      logic do_append;   // append to active slot
      logic release_one; // release scanned slot if eligible
      logic pick_recy;   // track best recyclable
      logic create;      // create chosen slot
      logic seal;        // seal active slot
      logic set_status;
      status_type status;
      logic rpt_active;  // report active slot
      logic rpt_pos;     // report position too
      logic rpt_sealed;  // report the slot just sealed
      logic out_load;    // move result to output register
   } cmd_type;

   typedef struct packed {
      logic       scan_last;
      logic       scan_ready;
      logic       scan_empty;
      logic       have_active;
      logic       best_valid;
      logic       can_create;
   } sts_type;
endpackage

FILE: src/lsrm_ctrl.sv
module lsrm_ctrl
   import lsrm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_go,
   input  logic [2:0]    req_mode,
   input  logic          out_free,
   input  sts_type       sts,
   output logic          busy,
   output cmd_type       cmd
);
   fsm_type state_ff, state_in;
   mode_type mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         mode_ff  <= MODE_APPEND;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd = '0;
      cmd.status = STS_OK;
      busy = 1'b1;
      case (state_ff)
         FSM_IDLE: begin
            busy = 1'b0;
            if (req_go) begin
               cmd.load = 1'b1;
               mode_in = mode_type'(req_mode);
               state_in = FSM_DISPATCH;
            end
         end
         FSM_DISPATCH: begin
            cmd.scan_clear = 1'b1;
            case (mode_ff)
               MODE_APPEND:
                  state_in = sts.have_active ? FSM_APPEND : FSM_ACT_SCAN;
               MODE_ROTATE, MODE_SEAL: begin
                  if (!sts.have_active) begin
                     cmd.set_status = 1'b1;
                     cmd.status = STS_NO_ACTIVE;
                     state_in = FSM_DONE;
                  end else begin
                     state_in = FSM_SEAL;
                  end
               end
               MODE_RELEASE: state_in = FSM_REL_SCAN;
               MODE_PRECREATE: begin
                  if (!sts.can_create) begin
                     cmd.set_status = 1'b1;
                     cmd.status = STS_NONE;
                     state_in = FSM_DONE;
                  end else begin
                     state_in = FSM_EMPTY_SCAN;
                  end
               end
               default: state_in = FSM_DONE;
            endcase
         end
         FSM_SEAL: begin
            cmd.seal = 1'b1;
            if (mode_ff == MODE_SEAL) begin
               cmd.rpt_sealed = 1'b1;
               state_in = FSM_DONE;
            end else begin
               state_in = FSM_ACT_SCAN;
            end
         end
         FSM_ACT_SCAN: begin
            if (sts.scan_ready) begin
               cmd.activate = 1'b1;
               state_in = (mode_ff == MODE_APPEND) ? FSM_APPEND : FSM_DONE;
               if (mode_ff != MODE_APPEND) begin
                  cmd.rpt_active = 1'b1;
                  cmd.rpt_pos = 1'b1;
               end
            end else if (sts.scan_last) begin
               cmd.set_status = 1'b1;
               cmd.status = STS_NO_READY;
               state_in = FSM_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         FSM_APPEND: begin
            cmd.do_append = 1'b1;
            cmd.rpt_active = 1'b1;
            cmd.rpt_pos = 1'b1;
            state_in = FSM_DONE;
         end
         FSM_REL_SCAN: begin
            cmd.release_one = 1'b1;
            if (sts.scan_last) state_in = FSM_DONE;
            else cmd.scan_step = 1'b1;
         end
         FSM_EMPTY_SCAN: begin
            if (sts.scan_empty) begin
               state_in = FSM_CREATE;
            end else if (sts.scan_last) begin
               cmd.scan_clear = 1'b1;
               state_in = FSM_RECY_SCAN;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         FSM_RECY_SCAN: begin
            cmd.pick_recy = 1'b1;
            if (sts.scan_last) state_in = FSM_CREATE;
            else cmd.scan_step = 1'b1;
         end
         FSM_CREATE: begin
            if (mode_ff == MODE_PRECREATE && !sts.scan_empty && !sts.best_valid) begin
               cmd.set_status = 1'b1;
               cmd.status = STS_NONE;
            end else begin
               cmd.create = 1'b1;
            end
            state_in = FSM_DONE;
         end
         FSM_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end
endmodule

FILE: src/lsrm_datapath.sv
module lsrm_datapath
   import lsrm_pkg::*;
#(
   parameter int unsigned RING_SLOTS   = RingSlotsDefault,
   parameter int unsigned HEADER_BYTES = HeaderBytesDefault,
   parameter int unsigned FOOTER_BYTES = FooterBytesDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   output sts_type       sts,
   input  logic [31:0]   req_block_bytes,
   input  logic [63:0]   req_log_number,
   input  logic [32:0]   cfg_size,
   input  logic [4:0]    cfg_used,
   input  logic [4:0]    cfg_target,
   output logic [2:0]    res_status,
   output logic [3:0]    res_slot_index,
   output logic [32:0]   res_write_position,
   output logic [63:0]   res_seg_seq,
   output logic [4:0]    res_ready_slots
);
   localparam int unsigned IW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int unsigned CW = $clog2(RING_SLOTS + 1);

   slot_state_type state_ff [RING_SLOTS];
   logic [RING_SLOTS-1:0] logged_ff;
   logic [63:0] seq_mem [RING_SLOTS];
   logic [32:0] off_mem [RING_SLOTS];
   logic [63:0] min_mem [RING_SLOTS];
   logic [63:0] max_mem [RING_SLOTS];

   logic          act_valid_ff;
   logic [IW-1:0] act_ff;
   logic [CW-1:0] ready_ff;
   logic [63:0]   next_seq_ff;
   logic [IW-1:0] scan_ff;
   logic          best_valid_ff;
   logic [IW-1:0] best_ff;
   logic [31:0]   len_ff;
   logic [63:0]   log_ff;
   logic [2:0]    o_status_ff;
   logic [IW-1:0] o_idx_ff;
   logic [32:0]   o_pos_ff;
   logic [63:0]   o_seq_ff;

   logic [4:0] used_clamp;
   logic [IW:0] last_idx;
   logic [32:0] data_end;
   logic [33:0] sum_w;
   logic        need_rot;
   logic [IW-1:0] pick;

   always_comb begin
      if (cfg_used > 5'(RING_SLOTS) && RING_SLOTS < 32) used_clamp = 5'(RING_SLOTS);
      else if (cfg_used < 5'd2) used_clamp = 5'd2;
      else used_clamp = cfg_used;
      last_idx = (IW+1)'(used_clamp - 5'd1);
      data_end = (cfg_size >= 33'(FOOTER_BYTES)) ? cfg_size - 33'(FOOTER_BYTES) : '0;
      sum_w = {1'b0, off_mem[act_ff]} + 34'(len_ff);
      need_rot = sum_w >= {1'b0, data_end};
      pick = (state_ff[scan_ff] == ST_EMPTY) ? scan_ff : best_ff;
   end

   assign sts.scan_last   = ({1'b0, scan_ff} == last_idx);
   assign sts.scan_ready  = (state_ff[scan_ff] == ST_READY);
   assign sts.scan_empty  = (state_ff[scan_ff] == ST_EMPTY);
   assign sts.have_active = act_valid_ff;
   assign sts.best_valid  = best_valid_ff;
   assign sts.can_create  = 5'(ready_ff) < cfg_target;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_SLOTS; i++) state_ff[i] <= ST_EMPTY;
         logged_ff     <= '0;
         act_valid_ff  <= 1'b0;
         act_ff        <= '0;
         ready_ff      <= '0;
         next_seq_ff   <= 64'd1;
         scan_ff       <= '0;
         best_valid_ff <= 1'b0;
         best_ff       <= '0;
         o_status_ff   <= STS_OK;
         o_idx_ff      <= '0;
         o_pos_ff      <= '0;
         o_seq_ff      <= '0;
         res_status    <= STS_OK;
         res_slot_index <= '0;
         res_write_position <= '0;
         res_seg_seq <= '0;
         res_ready_slots <= '0;
      end else begin
         if (cmd.load) begin
            len_ff <= req_block_bytes;
            log_ff <= req_log_number;
            o_status_ff <= STS_OK;
            o_idx_ff <= '0;
            o_pos_ff <= '0;
            o_seq_ff <= '0;
            best_valid_ff <= 1'b0;
         end
         if (cmd.scan_clear) scan_ff <= '0;
         else if (cmd.scan_step) scan_ff <= scan_ff + 1'b1;
         if (cmd.set_status) o_status_ff <= cmd.status;
         if (cmd.seal) begin
            state_ff[act_ff] <= ST_SEALED;
            act_valid_ff <= 1'b0;
         end
         if (cmd.rpt_sealed) begin
            o_idx_ff <= act_ff;
            o_seq_ff <= seq_mem[act_ff];
         end
         if (cmd.activate) begin
            state_ff[scan_ff] <= ST_ACTIVE;
            logged_ff[scan_ff] <= 1'b0;
            act_ff <= scan_ff;
            act_valid_ff <= 1'b1;
            if (ready_ff != '0) ready_ff <= ready_ff - 1'b1;
            if (cmd.rpt_active) begin
               o_idx_ff <= scan_ff;
               o_seq_ff <= seq_mem[scan_ff];
               o_pos_ff <= 33'(HEADER_BYTES);
            end
         end
         if (cmd.do_append) begin
            o_idx_ff <= act_ff;
            o_seq_ff <= seq_mem[act_ff];
            o_pos_ff <= off_mem[act_ff];
            if (need_rot) o_status_ff <= STS_ROTATE;
            else logged_ff[act_ff] <= 1'b1;
         end
         if (cmd.release_one && state_ff[scan_ff] == ST_SEALED
               && max_mem[scan_ff] <= log_ff)
            state_ff[scan_ff] <= ST_RECYCLABLE;
         if (cmd.pick_recy && state_ff[scan_ff] == ST_RECYCLABLE
               && (!best_valid_ff || seq_mem[scan_ff] < seq_mem[best_ff])) begin
            best_valid_ff <= 1'b1;
            best_ff <= scan_ff;
         end
         if (cmd.create) begin
            state_ff[pick] <= ST_READY;
            logged_ff[pick] <= 1'b0;
            next_seq_ff <= next_seq_ff + 64'd1;
            ready_ff <= ready_ff + 1'b1;
            o_idx_ff <= pick;
            o_seq_ff <= next_seq_ff;
         end
         if (cmd.out_load) begin
            res_status <= o_status_ff;
            res_slot_index <= 4'(o_idx_ff);
            res_write_position <= o_pos_ff;
            res_seg_seq <= o_seq_ff;
            res_ready_slots <= 5'(ready_ff);
         end
      end
   end

   // slot payload, reset values come from the clear loop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_SLOTS; i++) begin
            seq_mem[i] <= '0;
            off_mem[i] <= '0;
            min_mem[i] <= '0;
            max_mem[i] <= '0;
         end
      end else begin
         if (cmd.activate) begin
            off_mem[scan_ff] <= 33'(HEADER_BYTES);
            min_mem[scan_ff] <= '0;
            max_mem[scan_ff] <= '0;
         end
         if (cmd.do_append && !need_rot) begin
            off_mem[act_ff] <= sum_w[32:0];
            if (!logged_ff[act_ff]) min_mem[act_ff] <= log_ff;
            max_mem[act_ff] <= log_ff;
         end
         if (cmd.create) begin
            seq_mem[pick] <= next_seq_ff;
            off_mem[pick] <= 33'(HEADER_BYTES);
            min_mem[pick] <= '0;
            max_mem[pick] <= '0;
         end
      end
   end
endmodule

FILE: src/log_segment_ring_manager.sv
// activation, rotate, release and precreate scan the slots in use, so their time to a
// valid result grows with slots_in_use; append with an active slot and seal do not scan
// one item at a time: a new request is taken only after the last result has moved to the
// output register, so a held result keeps the next item waiting
// reset: synchronous, all slots empty, no active slot, next sequence one
module log_segment_ring_manager
   import lsrm_pkg::*;
#(
   parameter int unsigned RING_SLOTS   = RingSlotsDefault,
   parameter int unsigned HEADER_BYTES = HeaderBytesDefault,
   parameter int unsigned FOOTER_BYTES = FooterBytesDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata, // mode, block_bytes, log_number, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata, // status, slot_index, write_position,
                                   // sequence number, ready_slots, pad
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   cmd_type cmd;
   sts_type sts;
   logic busy, rsp_valid_ff;
   logic [32:0] size_ff;
   logic [4:0] used_ff, target_ff;
   logic [2:0] r_status;
   logic [3:0] r_idx;
   logic [32:0] r_pos;
   logic [63:0] r_seq;
   logic [4:0] r_ready;
   logic wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite & csr_pready;
   // 33-bit register, so 8 byte stride
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 33'd67108864;
         used_ff <= 5'd4;
         target_ff <= 5'd1;
      end else if (wr) begin
         case (csr_paddr[4:3])
            REG_SIZE: size_ff <= csr_pwdata[32:0];
            REG_USED: used_ff <= csr_pwdata[4:0];
            REG_TARGET: target_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         REG_SIZE: csr_prdata = 64'(size_ff);
         REG_USED: csr_prdata = 64'(used_ff);
         REG_TARGET: csr_prdata = 64'(target_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign req_tready = !busy;
   lsrm_ctrl u_ctrl (
      .clock, .reset,
      .req_go(req_tvalid && req_tready), .req_mode(req_tdata[2:0]),
      .out_free(!rsp_valid_ff || rsp_tready), .sts, .busy, .cmd);

   lsrm_datapath #(.RING_SLOTS(RING_SLOTS), .HEADER_BYTES(HEADER_BYTES),
      .FOOTER_BYTES(FOOTER_BYTES)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_block_bytes(req_tdata[34:3]),
      .req_log_number(req_tdata[98:35]),
      .cfg_size(size_ff), .cfg_used(used_ff), .cfg_target(target_ff),
      .res_status(r_status), .res_slot_index(r_idx), .res_write_position(r_pos),
      .res_seg_seq(r_seq), .res_ready_slots(r_ready));

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'd0, r_ready, r_seq, r_pos, r_idx, r_status};
endmodule

FILE: src/lsrm_checker.sv
`include "log_segment_ring_manager_macros.svh"
module lsrm_checker
   import lsrm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [111:0] rsp_tdata
);
   `LSRM_ASSERT(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `LSRM_ASSERT(a_one, clock, reset, req_tvalid && req_tready |=> !req_tready)
   `LSRM_ASSERT(a_status, clock, reset, rsp_tvalid |-> rsp_tdata[2:0] <= STS_NONE)
   `LSRM_ASSERT_NR(a_rst, clock, reset |=> !rsp_tvalid)
endmodule

bind log_segment_ring_manager lsrm_checker u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata);
